// ===== hdl/mcrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and lookup tables for the mesh cell refinement pattern block.
package mcrp_pkg;

    // Cell kinds
    localparam logic [1:0] KIND_POINT    = 2'd0;
    localparam logic [1:0] KIND_SEGMENT  = 2'd1;
    localparam logic [1:0] KIND_TRIANGLE = 2'd2;
    localparam logic [1:0] KIND_QUAD     = 2'd3;

    // Refinement patterns
    localparam logic [3:0] PAT_NIL          = 4'd0;
    localparam logic [3:0] PAT_COPY         = 4'd1;
    localparam logic [3:0] PAT_SPLIT        = 4'd2;
    localparam logic [3:0] PAT_BISECT       = 4'd3;
    localparam logic [3:0] PAT_TRISECT      = 4'd4;
    localparam logic [3:0] PAT_TRISECT_LEFT = 4'd5;
    localparam logic [3:0] PAT_QUADSECT     = 4'd6;
    localparam logic [3:0] PAT_THREEEDGE    = 4'd7;
    localparam logic [3:0] PAT_REGULAR      = 4'd8;
    localparam logic [3:0] PAT_BARYCENTRIC  = 4'd9;

    // Vertex codes: corners, midpoints, centre at half, centre at third
    localparam logic [3:0] V_N0 = 4'd0;
    localparam logic [3:0] V_N1 = 4'd1;
    localparam logic [3:0] V_N2 = 4'd2;
    localparam logic [3:0] V_N3 = 4'd3;
    localparam logic [3:0] V_M0 = 4'd4;
    localparam logic [3:0] V_M1 = 4'd5;
    localparam logic [3:0] V_M2 = 4'd6;
    localparam logic [3:0] V_M3 = 4'd7;
    localparam logic [3:0] V_CH = 4'd8;
    localparam logic [3:0] V_CT = 4'd9;

    localparam int ROW_W = 6;
    localparam logic [15:0] LATTICE_RESET = 16'd6;

    typedef struct packed {
        logic [1:0] cell_kind;
        logic [3:0] pattern;
        logic [1:0] anchor;
        logic       anchor_valid;
    } item_t;

    typedef struct packed {
        logic [2:0]  child_index;
        logic [2:0]  vertex_count;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] x3;
        logic [15:0] y3;
        logic        last;
        logic        error;
    } res_t;

    // One queued refinement job, already classified
    typedef struct packed {
        logic [1:0]       kind;
        logic [ROW_W-1:0] first;
        logic [2:0]       count;
        logic [1:0]       anchor;
        logic             err;
    } job_t;

    typedef struct packed {
        logic             legal;
        logic             anchored;
        logic [ROW_W-1:0] first;
        logic [2:0]       count;
    } grp_t;

    typedef struct packed {
        logic [2:0] nv;
        logic [3:0] v0;
        logic [3:0] v1;
        logic [3:0] v2;
        logic [3:0] v3;
    } row_t;

    typedef enum logic [1:0] {SEL_ZERO, SEL_HALF, SEL_ONE, SEL_THIRD} coord_sel_t;

    typedef struct packed {
        coord_sel_t x;
        coord_sel_t y;
    } vsel_t;

    function automatic grp_t mk_grp(logic anch, int unsigned first, int unsigned count);
        grp_t g;
        g.legal    = 1'b1;
        g.anchored = anch;
        g.first    = ROW_W'(first);
        g.count    = 3'(count);
        return g;
    endfunction

    // Locate the run of child rows for a cell kind and pattern
    function automatic grp_t classify(logic [1:0] kind, logic [3:0] pat);
        grp_t g;
        g = '0;
        case ({kind, pat})
            {KIND_POINT, PAT_COPY}:             g = mk_grp(1'b0, 0, 1);
            {KIND_SEGMENT, PAT_COPY}:           g = mk_grp(1'b0, 1, 1);
            {KIND_SEGMENT, PAT_SPLIT}:          g = mk_grp(1'b0, 2, 2);
            {KIND_TRIANGLE, PAT_COPY}:          g = mk_grp(1'b0, 4, 1);
            {KIND_TRIANGLE, PAT_BISECT}:        g = mk_grp(1'b1, 5, 2);
            {KIND_TRIANGLE, PAT_TRISECT}:       g = mk_grp(1'b1, 7, 3);
            {KIND_TRIANGLE, PAT_TRISECT_LEFT}:  g = mk_grp(1'b1, 10, 3);
            {KIND_TRIANGLE, PAT_QUADSECT}:      g = mk_grp(1'b1, 13, 4);
            {KIND_TRIANGLE, PAT_REGULAR}:       g = mk_grp(1'b0, 17, 4);
            {KIND_TRIANGLE, PAT_BARYCENTRIC}:   g = mk_grp(1'b0, 21, 6);
            {KIND_QUAD, PAT_COPY}:              g = mk_grp(1'b0, 27, 1);
            {KIND_QUAD, PAT_TRISECT}:           g = mk_grp(1'b1, 28, 3);
            {KIND_QUAD, PAT_QUADSECT}:          g = mk_grp(1'b1, 31, 4);
            {KIND_QUAD, PAT_SPLIT}:             g = mk_grp(1'b1, 35, 2);
            {KIND_QUAD, PAT_BISECT}:            g = mk_grp(1'b1, 37, 2);
            {KIND_QUAD, PAT_THREEEDGE}:         g = mk_grp(1'b1, 39, 4);
            {KIND_QUAD, PAT_REGULAR}:           g = mk_grp(1'b0, 43, 4);
            {KIND_QUAD, PAT_BARYCENTRIC}:       g = mk_grp(1'b0, 47, 4);
            default:                            g = '0;
        endcase
        return g;
    endfunction

    function automatic row_t mk_row(int unsigned nv, logic [3:0] a, logic [3:0] b,
                                    logic [3:0] c, logic [3:0] d);
        row_t r;
        r.nv = 3'(nv);
        r.v0 = a;
        r.v1 = b;
        r.v2 = c;
        r.v3 = d;
        return r;
    endfunction

    // Child polygon table; unused vertex slots hold V_N0
    function automatic row_t row_at(logic [ROW_W-1:0] idx);
        row_t r;
        case (idx)
            6'd0:  r = mk_row(0, V_N0, V_N0, V_N0, V_N0);
            6'd1:  r = mk_row(2, V_N0, V_N1, V_N0, V_N0);
            6'd2:  r = mk_row(2, V_N0, V_M0, V_N0, V_N0);
            6'd3:  r = mk_row(2, V_M0, V_N1, V_N0, V_N0);
            6'd4:  r = mk_row(3, V_N0, V_N1, V_N2, V_N0);
            6'd5:  r = mk_row(3, V_N0, V_M0, V_N2, V_N0);
            6'd6:  r = mk_row(3, V_N1, V_M0, V_N2, V_N0);
            6'd7:  r = mk_row(3, V_N0, V_M0, V_N2, V_N0);
            6'd8:  r = mk_row(3, V_N1, V_M0, V_M1, V_N0);
            6'd9:  r = mk_row(3, V_N2, V_M0, V_M2, V_N0);
            6'd10: r = mk_row(3, V_N0, V_M0, V_M2, V_N0);
            6'd11: r = mk_row(3, V_N1, V_M0, V_N2, V_N0);
            6'd12: r = mk_row(3, V_N2, V_M0, V_M2, V_N0);
            6'd13: r = mk_row(3, V_N0, V_M0, V_M2, V_N0);
            6'd14: r = mk_row(3, V_N1, V_M0, V_M1, V_N0);
            6'd15: r = mk_row(3, V_N2, V_M0, V_M1, V_N0);
            6'd16: r = mk_row(3, V_N2, V_M0, V_M2, V_N0);
            6'd17: r = mk_row(3, V_N0, V_M0, V_M2, V_N0);
            6'd18: r = mk_row(3, V_N1, V_M0, V_M1, V_N0);
            6'd19: r = mk_row(3, V_N2, V_M2, V_M1, V_N0);
            6'd20: r = mk_row(3, V_M0, V_M1, V_M2, V_N0);
            6'd21: r = mk_row(3, V_N0, V_M0, V_CT, V_N0);
            6'd22: r = mk_row(3, V_N1, V_M0, V_CT, V_N0);
            6'd23: r = mk_row(3, V_N1, V_M1, V_CT, V_N0);
            6'd24: r = mk_row(3, V_N2, V_M1, V_CT, V_N0);
            6'd25: r = mk_row(3, V_N2, V_M2, V_CT, V_N0);
            6'd26: r = mk_row(3, V_N0, V_M2, V_CT, V_N0);
            6'd27: r = mk_row(4, V_N0, V_N1, V_N2, V_N3);
            6'd28: r = mk_row(3, V_M0, V_N2, V_N3, V_N0);
            6'd29: r = mk_row(3, V_M0, V_N0, V_N3, V_N0);
            6'd30: r = mk_row(3, V_M0, V_N1, V_N2, V_N0);
            6'd31: r = mk_row(3, V_N0, V_N3, V_M0, V_N0);
            6'd32: r = mk_row(3, V_N1, V_M1, V_M0, V_N0);
            6'd33: r = mk_row(3, V_N2, V_N3, V_M1, V_N0);
            6'd34: r = mk_row(3, V_M0, V_M1, V_N3, V_N0);
            6'd35: r = mk_row(4, V_N0, V_M0, V_M2, V_N3);
            6'd36: r = mk_row(4, V_N1, V_N2, V_M2, V_M0);
            6'd37: r = mk_row(4, V_N0, V_M0, V_M2, V_N3);
            6'd38: r = mk_row(4, V_N1, V_N2, V_M2, V_M0);
            6'd39: r = mk_row(4, V_N2, V_N3, V_M3, V_M1);
            6'd40: r = mk_row(3, V_N0, V_M0, V_M3, V_N0);
            6'd41: r = mk_row(3, V_N1, V_M0, V_M1, V_N0);
            6'd42: r = mk_row(3, V_M0, V_M1, V_M3, V_N0);
            6'd43: r = mk_row(4, V_N0, V_M0, V_CH, V_M3);
            6'd44: r = mk_row(4, V_N1, V_M1, V_CH, V_M0);
            6'd45: r = mk_row(4, V_N2, V_M1, V_CH, V_M2);
            6'd46: r = mk_row(4, V_N3, V_M2, V_CH, V_M3);
            6'd47: r = mk_row(4, V_N0, V_M0, V_CH, V_M3);
            6'd48: r = mk_row(4, V_N1, V_M1, V_CH, V_M0);
            6'd49: r = mk_row(4, V_N2, V_M1, V_CH, V_M2);
            6'd50: r = mk_row(4, V_N3, V_M2, V_CH, V_M3);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Coordinate selectors of one vertex, corner/midpoint index rotated by the anchor
    function automatic vsel_t vertex_sel(logic [1:0] kind, logic [3:0] code, logic [1:0] a);
        vsel_t      s;
        logic [2:0] k;
        logic [1:0] idx;
        logic       is_mid;
        s.x    = SEL_ZERO;
        s.y    = SEL_ZERO;
        k      = {1'b0, code[1:0]} + {1'b0, a};
        is_mid = code[2];
        idx    = 2'd0;
        if (code == V_CH) begin
            s.x = SEL_HALF;
            s.y = SEL_HALF;
        end
        else if (code == V_CT) begin
            s.x = SEL_THIRD;
            s.y = SEL_THIRD;
        end
        else begin
            case (kind)
                KIND_SEGMENT:
                begin
                    if (code == V_M0) begin
                        s.x = SEL_HALF;
                    end
                    else if (code == V_N1) begin
                        s.x = SEL_ONE;
                    end
                end
                KIND_TRIANGLE:
                begin
                    if (k >= 3'd6) begin
                        idx = 2'(k - 3'd6);
                    end
                    else if (k >= 3'd3) begin
                        idx = 2'(k - 3'd3);
                    end
                    else begin
                        idx = k[1:0];
                    end
                    case ({is_mid, idx})
                        3'b001:  s.x = SEL_ONE;
                        3'b010:  s.y = SEL_ONE;
                        3'b100:  s.x = SEL_HALF;
                        3'b101:
                        begin
                            s.x = SEL_HALF;
                            s.y = SEL_HALF;
                        end
                        3'b110:  s.y = SEL_HALF;
                        default: s = {SEL_ZERO, SEL_ZERO};
                    endcase
                end
                KIND_QUAD:
                begin
                    idx = k[1:0];
                    case ({is_mid, idx})
                        3'b000:  s = {SEL_ZERO, SEL_ZERO};
                        3'b001:  s = {SEL_ONE, SEL_ZERO};
                        3'b010:  s = {SEL_ONE, SEL_ONE};
                        3'b011:  s = {SEL_ZERO, SEL_ONE};
                        3'b100:  s = {SEL_HALF, SEL_ZERO};
                        3'b101:  s = {SEL_ONE, SEL_HALF};
                        3'b110:  s = {SEL_HALF, SEL_ONE};
                        default: s = {SEL_ZERO, SEL_HALF};
                    endcase
                end
                default: s = {SEL_ZERO, SEL_ZERO};
            endcase
        end
        return s;
    endfunction

endpackage

// ===== hdl/mcrp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues a job.
module mcrp_front import mcrp_pkg::*;
(
    input  logic  push,
    input  item_t item,
    input  logic  job_full,
    output logic  full,
    output logic  job_push,
    output job_t  job
);

    grp_t grp;
    logic bad;

    always_comb
    begin
        grp = classify(item.cell_kind, item.pattern);
        // Illegal pattern, or anchored pattern without an anchor
        bad = !grp.legal || (grp.anchored && !item.anchor_valid);

        job.kind   = item.cell_kind;
        job.err    = bad;
        job.first  = bad ? '0 : grp.first;
        job.count  = bad ? 3'd1 : grp.count;
        job.anchor = grp.anchored ? item.anchor : 2'd0;

        full = job_full;
        // Drop nil transactions here: they produce nothing
        job_push = push && !job_full && (item.pattern != PAT_NIL);
    end

endmodule

// ===== hdl/mcrp_job_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the child sequencer.
module mcrp_job_fifo import mcrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    input  logic rd,
    output job_t rd_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    always_comb
    begin
        full        = (cnt_reg == 2'd2);
        empty       = (cnt_reg == 2'd0);
        do_wr       = wr && !full;
        do_rd       = rd && !empty;
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        rd_job      = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/mcrp_back.sv =====
`timescale 1ns / 1ps
// Back end: emits a job's child rows, one per cycle unless output is held.
module mcrp_back import mcrp_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] lattice,
    input  logic        job_empty,
    input  job_t        job,
    output logic        job_pop,
    input  logic        pop,
    output logic        empty,
    output res_t        result
);

    localparam logic [16:0] RECIP3 = 17'h0AAAB;  // ceil(2^17 / 3)

    logic [COORD_WIDTH-1:0] one_reg, half_reg, third_reg;
    logic [COORD_WIDTH-1:0] one_next, half_next, third_next;
    logic [15:0]            one16;
    logic [32:0]            prod;

    logic             busy_reg, busy_next;
    job_t             cur_reg, cur_next;
    logic [2:0]       step_reg, step_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic                   out_free;
    logic                   emit;
    logic                   fin;
    row_t                   row;
    logic [3:0]             codes [4];
    vsel_t                  vs [4];
    logic [COORD_WIDTH-1:0] xs [4];
    logic [COORD_WIDTH-1:0] ys [4];
    res_t                   built;

    function automatic logic [COORD_WIDTH-1:0] pick(coord_sel_t s,
                                                    logic [COORD_WIDTH-1:0] h,
                                                    logic [COORD_WIDTH-1:0] o,
                                                    logic [COORD_WIDTH-1:0] t);
        logic [COORD_WIDTH-1:0] v;
        case (s)
            SEL_HALF:  v = h;
            SEL_ONE:   v = o;
            SEL_THIRD: v = t;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // Scale values, refreshed every cycle from the lattice register
    always_comb
    begin
        one_next   = COORD_WIDTH'(lattice);
        half_next  = one_next >> 1;
        one16      = 16'(one_next);
        prod       = {16'd0, one16} * {16'd0, RECIP3};
        third_next = COORD_WIDTH'(prod[32:17]);
    end

    always_comb
    begin
        out_free = !out_valid_reg || pop;
        emit     = busy_reg && out_free;
        fin      = emit && (step_reg == 3'(cur_reg.count - 3'd1));
        job_pop  = !job_empty && (!busy_reg || fin);

        busy_next = job_pop ? 1'b1 : (fin ? 1'b0 : busy_reg);
        cur_next  = job_pop ? job : cur_reg;
        step_next = job_pop ? 3'd0 : (emit ? 3'(step_reg + 3'd1) : step_reg);
        row_next  = job_pop ? job.first : (emit ? ROW_W'(row_reg + 1'b1) : row_reg);

        row      = row_at(row_reg);
        codes[0] = row.v0;
        codes[1] = row.v1;
        codes[2] = row.v2;
        codes[3] = row.v3;
        for (int j = 0; j < 4; j++) begin
            vs[j] = vertex_sel(cur_reg.kind, codes[j], cur_reg.anchor);
            if (!cur_reg.err && (3'(j) < row.nv)) begin
                xs[j] = pick(vs[j].x, half_reg, one_reg, third_reg);
                ys[j] = pick(vs[j].y, half_reg, one_reg, third_reg);
            end
            else begin
                xs[j] = '0;
                ys[j] = '0;
            end
        end

        built.child_index  = cur_reg.err ? 3'd0 : step_reg;
        built.vertex_count = cur_reg.err ? 3'd0 : row.nv;
        built.x0           = 16'(xs[0]);
        built.y0           = 16'(ys[0]);
        built.x1           = 16'(xs[1]);
        built.y1           = 16'(ys[1]);
        built.x2           = 16'(xs[2]);
        built.y2           = 16'(ys[2]);
        built.x3           = 16'(xs[3]);
        built.y3           = 16'(ys[3]);
        built.last         = (step_reg == 3'(cur_reg.count - 3'd1));
        built.error        = cur_reg.err;

        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
        res_next       = emit ? built : res_reg;

        empty  = !out_valid_reg;
        result = res_reg;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            one_reg       <= '0;
            half_reg      <= '0;
            third_reg     <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= 3'd0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            one_reg       <= one_next;
            half_reg      <= half_next;
            third_reg     <= third_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/mesh_cell_refinement_pattern.sv =====
`timescale 1ns / 1ps
// Top level of the mesh cell refinement pattern generator.
//
// Each input transaction names a cell kind, a refinement pattern and an
// optional anchor edge; the block returns the child polygons of that
// refinement, one result transaction per child, in table order, with last set
// on the final child. Vertices are lattice points built from the configured
// lattice size (one), one/2 and one/3, computed on COORD_WIDTH bits and shown
// in the low 16 bits. An illegal pattern, or an anchored pattern without an
// anchor, gives a single result with error and last set and all else zero; a
// nil pattern gives no result. Rate: the child sequencer emits one result per
// cycle while the output register is free; an item has 1 to 6 children (an
// error or copy has 1) and a nil item takes none of its time. The front end
// classifies in the accept cycle and queues the job in a two-entry queue; the
// job then moves into the sequencer's job register before its first result.
// Results sit in an output register; while a result waits to be popped the
// sequencer holds, and input keeps flowing only until the two-entry job queue
// fills, after which full stays high until the results drain. Write
// lattice_size only while the block is idle; the new value holds for items
// accepted from the next cycle on.
module mesh_cell_refinement_pattern import mcrp_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    input  item_t       item,
    output logic        full,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output res_t        result,
    // lattice_size register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0] lattice_reg;
    logic [15:0] lattice_next;

    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_empty;
    logic job_pop;
    job_t job_head;

    // Hold the lattice size until the next write
    always_comb
    begin
        lattice_next = cfg_wr_en ? cfg_wr_data : lattice_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lattice_reg <= LATTICE_RESET;
        end
        else begin
            lattice_reg <= lattice_next;
        end
    end

    // Classify the incoming transaction; drop nil patterns
    mcrp_front u_front
    (
        .push     (push),
        .item     (item),
        .job_full (job_full),
        .full     (full),
        .job_push (job_push),
        .job      (job_in)
    );

    // Decouple classification from child emission
    mcrp_job_fifo u_job_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .rd     (job_pop),
        .rd_job (job_head),
        .full   (job_full),
        .empty  (job_empty)
    );

    // Advance through the child rows, one result per cycle while output is free
    mcrp_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .lattice   (lattice_reg),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ===== hdl/mcrp_check.sv =====
`timescale 1ns / 1ps
// Port-level checker for the refinement pattern block, bound to the top level.
module mcrp_check import mcrp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input res_t result
);

    // A waiting result stays until popped
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before pop");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("result changed while waiting");

    // An error transaction is a lone, empty result
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.error |-> result.last && (result.vertex_count == 3'd0)
                                   && (result.child_index == 3'd0) && (result.x0 == 16'd0))
        else $error("malformed error result");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.vertex_count == 3'd0) || (result.vertex_count == 3'd2)
                   || (result.vertex_count == 3'd3) || (result.vertex_count == 3'd4))
        else $error("illegal vertex count");

    // Vertices beyond the count read as zero; only the fourth is checked here
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result.vertex_count != 3'd4) |-> (result.x3 == 16'd0) && (result.y3 == 16'd0))
        else $error("unused vertex not zero");

endmodule

bind mesh_cell_refinement_pattern mcrp_check u_mcrp_check
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
